[rtl/csvkh_pkg.sv]
// package: payload types, phase codes and character constants for the csv key hasher
package csvkh_pkg;

  localparam int HASH_BITS = 64;
  localparam int CFG_IDX_BITS = 1;
  localparam int CFG_DATA_BITS = 8;

  localparam logic [HASH_BITS-1:0] HASH_START = 64'd5381;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_NEWLINE = 8'h0A;
  localparam logic [7:0] CH_NUL = 8'h00;

  localparam logic [CFG_IDX_BITS-1:0] REG_FIELD_NUMBER = 1'b0;
  localparam logic [CFG_IDX_BITS-1:0] REG_KEY_CHARS = 1'b1;

  typedef enum logic [3:0] {
    PH_SKIP    = 4'b0001,
    PH_COLLECT = 4'b0010,
    PH_DONE    = 4'b0100,
    PH_IDLE    = 4'b1000
  } phase_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_input;
  } in_t;

  typedef struct packed {
    logic [63:0] key_hash;
    logic [31:0] line_offset;
  } out_t;

  typedef struct packed {
    logic emit;
    out_t data;
  } scan_res_t;

endpackage

[rtl/csvkh_scan.sv]
// line scanner: column skip, key collection, djb2 update and line offset tracking
module csvkh_scan import csvkh_pkg::*; #(
  parameter int OFFSET_BITS = 32
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       step,
  input  in_t        in_item,
  input  logic [7:0] field_number,
  input  logic [7:0] key_chars,
  output scan_res_t  res
);

  logic [OFFSET_BITS-1:0] pos_r, pos_nxt;
  logic [OFFSET_BITS-1:0] line_start_r, line_start_nxt;
  logic [7:0]             skip_r, skip_nxt;
  logic [7:0]             taken_r, taken_nxt;
  logic [HASH_BITS-1:0]   hash_r, hash_nxt;
  phase_t                 phase_r, phase_nxt;

  logic [7:0]             b;
  logic                   newline;
  logic                   emit;
  logic [7:0]             skip_count;
  logic [7:0]             skip_dec;
  logic [HASH_BITS-1:0]   sb;
  logic [HASH_BITS-1:0]   hash_upd;
  logic [OFFSET_BITS-1:0] pos_inc;
  logic [63:0]            ls_ext;

  assign b          = in_item.data_byte;
  assign newline    = (b == CH_NEWLINE);
  assign emit       = newline || in_item.end_of_input;
  assign skip_count = (field_number == 8'd0) ? 8'd0 : field_number - 8'd1;
  assign sb         = {{(HASH_BITS-8){b[7]}}, b};
  assign pos_inc    = pos_r + {{(OFFSET_BITS-1){1'b0}}, 1'b1};
  assign ls_ext     = 64'(line_start_r);

  always_comb begin
    skip_nxt       = skip_r;
    phase_nxt      = phase_r;
    taken_nxt      = taken_r;
    hash_nxt       = hash_r;
    pos_nxt        = pos_inc;
    line_start_nxt = line_start_r;
    skip_dec       = 8'd0;
    hash_upd       = 64'd0;

    // first byte of a line picks up the column to use
    if (phase_r == PH_IDLE) begin
      skip_nxt  = skip_count;
      phase_nxt = (skip_count == 8'd0) ? PH_COLLECT : PH_SKIP;
    end

    if (!newline) begin
      if (b == CH_NUL) begin
        phase_nxt = PH_DONE;
      end else if (phase_nxt == PH_SKIP) begin
        if (b == CH_COMMA) begin
          skip_dec = skip_nxt - 8'd1;
          skip_nxt = skip_dec;
          if (skip_dec == 8'd0) begin
            phase_nxt = PH_COLLECT;
          end
        end
      end else if (phase_nxt == PH_COLLECT) begin
        if (taken_r >= key_chars || b == CH_COMMA) begin
          phase_nxt = PH_DONE;
        end else if (b != CH_QUOTE) begin
          // hash * 33 + signed byte
          hash_upd  = (hash_r << 5) + hash_r + sb;
          hash_nxt  = hash_upd;
          taken_nxt = taken_r + 8'd1;
        end
      end
    end

    res.emit             = emit;
    res.data.key_hash    = hash_nxt;
    res.data.line_offset = ls_ext[31:0];

    if (emit) begin
      if (in_item.end_of_input) begin
        pos_nxt        = '0;
        line_start_nxt = '0;
      end else begin
        line_start_nxt = pos_inc;
      end
      skip_nxt  = skip_count;
      taken_nxt = 8'd0;
      hash_nxt  = HASH_START;
      phase_nxt = PH_IDLE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r        <= '0;
      line_start_r <= '0;
      skip_r       <= 8'd0;
      taken_r      <= 8'd0;
      hash_r       <= HASH_START;
      phase_r      <= PH_IDLE;
    end else if (step) begin
      pos_r        <= pos_nxt;
      line_start_r <= line_start_nxt;
      skip_r       <= skip_nxt;
      taken_r      <= taken_nxt;
      hash_r       <= hash_nxt;
      phase_r      <= phase_nxt;
    end
  end

  // line state is cleared after every emitted request
  a_line_clear: assert property (@(posedge clk) disable iff (!rst_n)
    step && emit |=> phase_r == PH_IDLE && taken_r == 8'd0 && hash_r == HASH_START)
    else $error("line state not cleared after result");

  // end of input restarts offsets
  a_stream_restart: assert property (@(posedge clk) disable iff (!rst_n)
    step && in_item.end_of_input |=> pos_r == '0 && line_start_r == '0)
    else $error("offsets not restarted at end of input");

  // offset advances by one on every mid-line byte
  a_pos_advance: assert property (@(posedge clk) disable iff (!rst_n)
    step && !emit |=> pos_r == OFFSET_BITS'($past(pos_r) + 1'b1))
    else $error("byte position did not advance");

  // no state change without a request
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !step |=> $stable(pos_r) && $stable(hash_r) && $stable(phase_r))
    else $error("scanner state moved while idle");

endmodule

[rtl/csvkh_outreg.sv]
// result register: holds one finished result while the consumer stalls
module csvkh_outreg import csvkh_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      load,
  input  scan_res_t res,
  input  logic      out_ready,
  output logic      can_load,
  output logic      out_valid,
  output out_t      out_data
);

  logic out_valid_r, out_valid_nxt;
  out_t out_data_r;

  assign can_load = !out_valid_r || out_ready;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (load) begin
      out_valid_nxt = res.emit;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load && res.emit) begin
      out_data_r <= res.data;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

[rtl/csv_field_key_hasher_top.sv]
// top level: csv key column djb2 hasher with config registers and result register
// a result is registered and valid in the cycle after the byte that ends its line is accepted
// throughput: one byte per cycle, sustained while the result side keeps up
// the rate is set by the scan and hash update, worked out combinationally per byte and feeding the result register
// reset (synchronous, active low): offsets zero, hash 5381, no result pending,
//   field_number back to 1 and key_chars back to 16
module csv_field_key_hasher_top import csvkh_pkg::*; #(
  parameter int OFFSET_BITS = 32
) (
  input  logic                     clk,
  input  logic                     rst_n,
  // byte stream requests
  input  logic                     in_valid,
  output logic                     in_ready,
  input  in_t                      in_data,
  // hash results
  output logic                     out_valid,
  input  logic                     out_ready,
  output out_t                     out_data,
  // register writes
  input  logic                     cfg_wr_en,
  input  logic [CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [CFG_DATA_BITS-1:0] cfg_wdata
);

  logic [7:0] field_number_r;
  logic [7:0] key_chars_r;
  logic       can_load;
  logic       step;
  scan_res_t  res;

  // config registers; field_number is sampled by the scanner only at line start
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      field_number_r <= 8'd1;
      key_chars_r    <= 8'd16;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_FIELD_NUMBER: field_number_r <= cfg_wdata;
        REG_KEY_CHARS:    key_chars_r    <= cfg_wdata;
        default:          ;
      endcase
    end
  end

  // a request is taken whenever the result register is empty or being drained;
  // a result waiting on a stalled consumer holds off the next request
  assign in_ready = can_load;
  assign step     = in_valid && can_load;

  // per-byte scan: column skip, quote drop, hash update, line offset
  csvkh_scan #(
    .OFFSET_BITS (OFFSET_BITS)
  ) u_scan (
    .clk          (clk),
    .rst_n        (rst_n),
    .step         (step),
    .in_item      (in_data),
    .field_number (field_number_r),
    .key_chars    (key_chars_r),
    .res          (res)
  );

  // result register; loads only on newline or end of input
  csvkh_outreg u_outreg (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (step),
    .res       (res),
    .out_ready (out_ready),
    .can_load  (can_load),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule

[tb/sv/csv_field_key_hasher_top_tb.sv]
// testbench: directed table and random csv lines checked against a djb2 key scan predictor
`timescale 1ns / 1ps

module csv_field_key_hasher_top_tb;
  import csvkh_pkg::*;

  localparam int OFFSET_BITS = 32;
  localparam int RANDOM_BYTES = 1450;
  localparam int PHASE_BYTES = 200;
  localparam int SETTLE_CYCLES = 4;
  localparam int DRAIN_LIMIT = 20000;
  localparam int MAX_REPORTS = 10;
  localparam int unsigned RUN_LIMIT_NS = 4_000_000;

  // hashes that can be worked out by hand: one key byte after the start value
  localparam logic [63:0] HASH_ONE_A = 64'd177670;  // 'a'
  localparam logic [63:0] HASH_ONE_B = 64'd177639;  // 'B'
  localparam logic [63:0] HASH_ONE_X = 64'd177693;  // 'x'

  typedef enum logic {ROW_BYTE, ROW_REG} row_kind_t;

  typedef struct packed {
    row_kind_t               kind;
    logic [CFG_IDX_BITS-1:0] reg_idx;
    logic [7:0]              value;
    logic                    last;
    logic                    typed;    // expected result given in the row
    logic [63:0]             hash;
    logic [31:0]             offset;
  } dir_row_t;

  logic                     clk = 1'b0;
  logic                     rst_n = 1'b0;
  logic                     in_valid = 1'b0;
  logic                     in_ready;
  in_t                      in_data = '0;
  logic                     out_valid;
  logic                     out_ready = 1'b0;
  out_t                     out_data;
  logic                     cfg_wr_en = 1'b0;
  logic [CFG_IDX_BITS-1:0]  cfg_index = '0;
  logic [CFG_DATA_BITS-1:0] cfg_wdata = '0;

  // predictor copy of the registers, reset values
  logic [7:0]             field_num_q = 8'd1;
  logic [7:0]             key_chars_q = 8'd16;
  // predictor copy of the scan state
  logic [OFFSET_BITS-1:0] pos_q = '0;
  logic [OFFSET_BITS-1:0] line_start_q = '0;
  logic [7:0]             skip_left_q = '0;
  logic [7:0]             taken_q = '0;
  logic [63:0]            hash_q = HASH_START;
  phase_t                 phase_q = PH_IDLE;

  out_t awaited_hashes [$];   // results predicted, oldest first
  int   mismatch_count = 0;
  int   bytes_sent = 0;
  int   tx_calm_left = 0;     // requests still to send back to back
  int   rx_calm_left = 0;     // cycles of steady out_ready
  int   rx_stall_left = 0;    // cycles of out_ready held low

  csv_field_key_hasher_top #(
    .OFFSET_BITS(OFFSET_BITS)
  ) DUT (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data(out_data),
    .cfg_wr_en(cfg_wr_en),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 0;
  end

  // directed part: extremes of the byte, signed bytes, quotes, every register,
  // zero field number, zero key length, nul byte, column past the end,
  // newline together with end of input, register write in the middle of a line
  dir_row_t directed_rows [31] = '{
    '{ROW_BYTE, '0, 8'h61,      1'b0, 1'b0, 64'd0,      32'd0},
    '{ROW_BYTE, '0, CH_NEWLINE, 1'b0, 1'b1, HASH_ONE_A, 32'd0},
    '{ROW_BYTE, '0, CH_NEWLINE, 1'b0, 1'b1, HASH_START, 32'd2},   // empty line
    '{ROW_BYTE, '0, 8'h80,      1'b0, 1'b0, 64'd0,      32'd0},   // most negative
    '{ROW_BYTE, '0, CH_QUOTE,   1'b0, 1'b0, 64'd0,      32'd0},
    '{ROW_BYTE, '0, 8'hFF,      1'b0, 1'b0, 64'd0,      32'd0},
    '{ROW_BYTE, '0, CH_COMMA,   1'b0, 1'b0, 64'd0,      32'd0},
    '{ROW_BYTE, '0, 8'h7F,      1'b0, 1'b0, 64'd0,      32'd0},
    '{ROW_BYTE, '0, CH_NEWLINE, 1'b0, 1'b0, 64'd0,      32'd0},
    '{ROW_REG,  REG_FIELD_NUMBER, 8'd0, 1'b0, 1'b0, 64'd0, 32'd0},
    '{ROW_BYTE, '0, CH_NUL,     1'b0, 1'b0, 64'd0,      32'd0},
    '{ROW_BYTE, '0, 8'h41,      1'b0, 1'b0, 64'd0,      32'd0},
    '{ROW_BYTE, '0, CH_NEWLINE, 1'b0, 1'b1, HASH_START, 32'd9},
    '{ROW_REG,  REG_KEY_CHARS, 8'd0, 1'b0, 1'b0, 64'd0, 32'd0},
    '{ROW_BYTE, '0, 8'h41,      1'b0, 1'b0, 64'd0,      32'd0},
    '{ROW_BYTE, '0, CH_NEWLINE, 1'b1, 1'b1, HASH_START, 32'd12},
    '{ROW_REG,  REG_KEY_CHARS, 8'd255, 1'b0, 1'b0, 64'd0, 32'd0},
    '{ROW_REG,  REG_FIELD_NUMBER, 8'd255, 1'b0, 1'b0, 64'd0, 32'd0},
    '{ROW_BYTE, '0, CH_COMMA,   1'b0, 1'b0, 64'd0,      32'd0},
    '{ROW_BYTE, '0, 8'h41,      1'b1, 1'b1, HASH_START, 32'd0},
    '{ROW_REG,  REG_FIELD_NUMBER, 8'd2, 1'b0, 1'b0, 64'd0, 32'd0},
    '{ROW_BYTE, '0, 8'h41,      1'b0, 1'b0, 64'd0,      32'd0},
    '{ROW_BYTE, '0, CH_COMMA,   1'b0, 1'b0, 64'd0,      32'd0},
    '{ROW_BYTE, '0, 8'h42,      1'b0, 1'b0, 64'd0,      32'd0},
    '{ROW_REG,  REG_FIELD_NUMBER, 8'd1, 1'b0, 1'b0, 64'd0, 32'd0},
    '{ROW_BYTE, '0, CH_QUOTE,   1'b0, 1'b0, 64'd0,      32'd0},
    '{ROW_BYTE, '0, CH_NEWLINE, 1'b0, 1'b1, HASH_ONE_B, 32'd0},
    '{ROW_REG,  REG_KEY_CHARS, 8'd1, 1'b0, 1'b0, 64'd0, 32'd0},
    '{ROW_BYTE, '0, 8'h78,      1'b0, 1'b0, 64'd0,      32'd0},
    '{ROW_BYTE, '0, 8'h79,      1'b0, 1'b0, 64'd0,      32'd0},   // past key length
    '{ROW_BYTE, '0, CH_NEWLINE, 1'b0, 1'b1, HASH_ONE_X, 32'd5}
  };

  // scan state back to "line not yet begun"
  function automatic void clear_line_scan();
    skip_left_q = (field_num_q == 8'd0) ? 8'd0 : field_num_q - 8'd1;
    taken_q = 8'd0;
    hash_q = HASH_START;
    phase_q = PH_IDLE;
  endfunction

  // advance the key scan by one accepted byte, returns 1 when a result is due
  function automatic bit advance_key_scan(input logic [7:0] b, input logic last,
                                          output out_t res);
    bit line_end;
    line_end = (b == CH_NEWLINE) || last;
    // first byte of a line latches the column to use
    if (phase_q == PH_IDLE) begin
      skip_left_q = (field_num_q == 8'd0) ? 8'd0 : field_num_q - 8'd1;
      phase_q = (skip_left_q == 8'd0) ? PH_COLLECT : PH_SKIP;
    end
    if (b != CH_NEWLINE) begin
      if (b == CH_NUL) begin
        phase_q = PH_DONE;
      end else if (phase_q == PH_SKIP) begin
        if (b == CH_COMMA) begin
          skip_left_q = skip_left_q - 8'd1;
          if (skip_left_q == 8'd0) phase_q = PH_COLLECT;
        end
      end else if (phase_q == PH_COLLECT) begin
        if (taken_q >= key_chars_q || b == CH_COMMA) begin
          phase_q = PH_DONE;
        end else if (b != CH_QUOTE) begin
          // djb2 step, the byte taken as signed
          hash_q = hash_q * 64'd33 + {{56{b[7]}}, b};
          taken_q = taken_q + 8'd1;
        end
      end
    end
    pos_q = pos_q + 1'b1;
    res = '{key_hash: hash_q, line_offset: line_start_q[31:0]};
    if (line_end) begin
      if (last) begin
        // end of stream: offsets restart, registers stay
        pos_q = '0;
        line_start_q = '0;
      end else begin
        line_start_q = pos_q;
      end
      clear_line_scan();
    end
    return line_end;
  endfunction

  task automatic flag_mismatch(input string what, input logic [63:0] want,
                               input logic [63:0] got);
    mismatch_count++;
    if (mismatch_count <= MAX_REPORTS)
      $display("mismatch at %0t: %s expected %h got %h", $realtime, what, want, got);
  endtask

  // sender gap: mostly none, some short, a few long, with calm stretches
  function automatic int pick_gap();
    int r;
    if (tx_calm_left != 0) begin
      tx_calm_left--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 3) begin
      tx_calm_left = $urandom_range(40, 300);
      return 0;
    end
    if (r < 70) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // one byte request; the prediction goes to the queue unless the row gives it
  task automatic send_byte(input logic [7:0] b, input logic last, input bit use_typed,
                           input out_t typed_res);
    int   gap;
    bit   line_end;
    out_t predicted;
    gap = pick_gap();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= '{data_byte: b, end_of_input: last};
    do @(posedge clk); while (!in_ready);
    bytes_sent++;
    line_end = advance_key_scan(b, last, predicted);
    if (line_end) begin
      if (use_typed) predicted = typed_res;
      awaited_hashes = {awaited_hashes, predicted};
    end
  endtask

  // stop sending and let every awaited result come back
  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(negedge clk); while (awaited_hashes.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // register write, block idle; the enable is lowered before the task returns so it does not toggle in one step
  task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx, input logic [7:0] val);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    if (idx == REG_FIELD_NUMBER) field_num_q = val;
    else key_chars_q = val;
    @(posedge clk);
  endtask

  function automatic logic [7:0] text_byte();
    int r;
    r = $urandom_range(0, 99);
    if (r < 6) return CH_QUOTE;
    if (r < 14) return 8'($urandom_range(128, 255));
    if (r < 17) return 8'($urandom_range(0, 255));   // anything, delimiters too
    return 8'($urandom_range(32, 126));
  endfunction

  // one csv line with random content; a tenth are random noise
  task automatic send_csv_line();
    logic [7:0] line_q [$];
    int         r;
    int         n_fields;
    int         len;
    bit         stream_end;
    r = $urandom_range(0, 99);
    if (r < 10) begin
      len = $urandom_range(1, 12);
      repeat (len) line_q = {line_q, 8'($urandom_range(0, 255))};
      stream_end = ($urandom_range(0, 19) == 0);
    end else begin
      n_fields = $urandom_range(1, 6);
      for (int f = 0; f < n_fields; f++) begin
        if (f != 0) line_q = {line_q, CH_COMMA};
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 24) : $urandom_range(0, 6);
        repeat (len) line_q = {line_q, text_byte()};
      end
      r = $urandom_range(0, 99);
      stream_end = (r >= 80);
      // most lines end in a newline, some also end the stream, some end it without
      if (r < 90) line_q = {line_q, CH_NEWLINE};
      else if (line_q.size() == 0) line_q = {line_q, text_byte()};
    end
    for (int i = 0; i < line_q.size(); i++)
      send_byte(line_q[i], stream_end && (i == line_q.size() - 1), 1'b0, '0);
  endtask

  // receiver stalls: mostly short, a few long, with steady stretches
  always @(posedge clk) begin
    int r;
    if (rx_calm_left != 0) begin
      rx_calm_left--;
      out_ready <= 1'b1;
    end else if (rx_stall_left != 0) begin
      rx_stall_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
      r = $urandom_range(0, 99);
      if (r < 3) rx_calm_left = $urandom_range(50, 300);
      else if (r < 6) rx_stall_left = $urandom_range(10, 40);
      else if (r < 30) rx_stall_left = $urandom_range(1, 3);
    end
  end

  // compare every accepted result with the oldest awaited one
  always @(posedge clk) begin
    out_t want;
    if (rst_n && out_valid && out_ready) begin
      if (awaited_hashes.size() == 0) begin
        flag_mismatch("result with none awaited, key_hash", '0, out_data.key_hash);
      end else begin
        want = awaited_hashes.pop_front();
        if (out_data.key_hash !== want.key_hash)
          flag_mismatch("key_hash", want.key_hash, out_data.key_hash);
        if (out_data.line_offset !== want.line_offset)
          flag_mismatch("line_offset", 64'(want.line_offset), 64'(out_data.line_offset));
      end
    end
  end

  initial begin : stimulus
    int   random_start;
    int   phase_start;
    int   ph;
    bit   paused;
    logic [7:0] field_sel;
    logic [7:0] key_len;
    out_t typed_res;

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // directed table
    foreach (directed_rows[i]) begin
      if (directed_rows[i].kind == ROW_REG) begin
        wait_drained();
        write_reg(directed_rows[i].reg_idx, directed_rows[i].value);
      end else begin
        typed_res = '{key_hash: directed_rows[i].hash, line_offset: directed_rows[i].offset};
        send_byte(directed_rows[i].value, directed_rows[i].last,
                  directed_rows[i].typed, typed_res);
      end
    end

    // random phases, each under its own register setting
    random_start = bytes_sent;
    ph = 0;
    while (bytes_sent - random_start < RANDOM_BYTES) begin
      case (ph)
        0: begin field_sel = 8'd1; key_len = 8'd255; end
        1: begin field_sel = 8'd2; key_len = 8'd1; end
        2: begin field_sel = 8'd3; key_len = 8'd8; end
        3: begin field_sel = 8'd0; key_len = 8'd4; end
        4: begin field_sel = 8'd255; key_len = 8'd0; end
        5: begin field_sel = 8'd5; key_len = 8'd16; end
        default: begin
          field_sel = 8'($urandom_range(1, 6));
          key_len = 8'($urandom_range(0, 20));
        end
      endcase
      wait_drained();
      write_reg(REG_FIELD_NUMBER, field_sel);
      write_reg(REG_KEY_CHARS, key_len);
      phase_start = bytes_sent;
      paused = 1'b0;
      while (bytes_sent - phase_start < PHASE_BYTES &&
             bytes_sent - random_start < RANDOM_BYTES) begin
        send_csv_line();
        // sender holds off mid-phase until everything is back
        if (!paused && bytes_sent - phase_start >= PHASE_BYTES / 2) begin
          wait_drained();
          paused = 1'b1;
        end
      end
      ph++;
    end

    // drain with a bound, then settle
    in_valid <= 1'b0;
    for (int n = 0; n < DRAIN_LIMIT && awaited_hashes.size() != 0; n++) @(negedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (awaited_hashes.size() != 0)
      flag_mismatch("results never returned, count", '0, 64'(awaited_hashes.size()));

    if (mismatch_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // watchdog for a hung handshake
  initial begin
    #(RUN_LIMIT_NS);
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
